### rtl/agcm_pkg.sv
// Shared types, constants and functions for the AES-128-GCM engine.
`default_nettype none
package agcm_pkg;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_AAD   = 2'd1;
    localparam logic [1:0] CMD_TEXT  = 2'd2;
    localparam logic [1:0] CMD_FIN   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOKEY  = 2'd1;
    localparam logic [1:0] ST_ORDER  = 2'd2;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_AAD    = 2'd1;
    localparam logic [1:0] PH_TEXT   = 2'd2;

    localparam logic [2:0] REG_KEY_HI   = 3'd0;
    localparam logic [2:0] REG_KEY_LO   = 3'd1;
    localparam logic [2:0] REG_NONCE_HI = 3'd2;
    localparam logic [2:0] REG_NONCE_LO = 3'd3;
    localparam logic [2:0] REG_DECRYPT  = 3'd4;

    localparam logic [35:0] AAD_MAX  = 36'hFFFFFFFFF;
    localparam logic [35:0] TEXT_MAX = 36'hFFFFFFFE0;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_KEY_INIT,
        OP_AES_ZERO,
        OP_AES_J0,
        OP_AES_CTR,
        OP_GHASH_AAD,
        OP_GHASH_TEXT,
        OP_GHASH_LEN
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       start;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
    } dp_sts_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [0:255];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte 0 sits in bits 127:120.
    function automatic logic [127:0] lead_mask(input logic [4:0] n);
        logic [127:0] m;
        m = '0;
        for (int i = 0; i < 16; i++) begin
            if (5'(i) < n) begin
                m[127 - 8*i -: 8] = 8'hff;
            end
        end
        return m;
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0] t [16];
        logic [7:0] u [16];
        logic [7:0] a, b, d, e;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            t[i] = sbox(s[127 - 8*i -: 8]);
        end
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                u[4*c + j] = t[4*((c + j) % 4) + j];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a = u[4*c]; b = u[4*c+1]; d = u[4*c+2]; e = u[4*c+3];
            if (!last) begin
                u[4*c]   = xtime(a) ^ xtime(b) ^ b ^ d ^ e;
                u[4*c+1] = a ^ xtime(b) ^ xtime(d) ^ d ^ e;
                u[4*c+2] = a ^ b ^ xtime(d) ^ xtime(e) ^ e;
                u[4*c+3] = xtime(a) ^ a ^ b ^ d ^ xtime(e);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8*i -: 8] = u[i];
        end
        return r;
    endfunction

    function automatic logic [127:0] key_step(input logic [127:0] p, input logic [7:0] rc);
        logic [31:0] t;
        logic [127:0] c;
        t = {sbox(p[23:16]) ^ rc, sbox(p[15:8]), sbox(p[7:0]), sbox(p[31:24])};
        c[127:96] = p[127:96] ^ t;
        c[95:64]  = p[95:64] ^ c[127:96];
        c[63:32]  = p[63:32] ^ c[95:64];
        c[31:0]   = p[31:0] ^ c[63:32];
        return c;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01;
            4'd2: v = 8'h02;
            4'd3: v = 8'h04;
            4'd4: v = 8'h08;
            4'd5: v = 8'h10;
            4'd6: v = 8'h20;
            4'd7: v = 8'h40;
            4'd8: v = 8'h80;
            4'd9: v = 8'h1b;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/agcm_datapath.sv
// Datapath: key schedule memory, iterative AES round unit and bit-serial GHASH multiplier.
`default_nettype none
module agcm_datapath
    import agcm_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire dp_cmd_t       cmd,
    output dp_sts_t            sts,
    input  wire logic [127:0]  key,
    input  wire logic [95:0]   nonce,
    input  wire logic [127:0]  blk,
    input  wire logic [4:0]    nbytes,
    input  wire logic          decrypt,
    input  wire logic [35:0]   aad_len,
    input  wire logic [35:0]   text_len,
    input  wire logic [31:0]   ctr,
    output logic [127:0]       text_out,
    output logic [127:0]       ghash_out,
    output logic [127:0]       mask_out
);

    logic [127:0] rk_mem [0:10];
    logic [127:0] rk_rd_reg;
    logic [3:0]   rk_addr;
    logic [127:0] state_reg;
    logic [127:0] expk_reg;
    logic [3:0]   rnd_reg;
    op_t          op_reg;
    logic         busy_reg;
    logic         kphase_reg;
    logic         rdwait_reg;
    logic [127:0] h_reg, mask_reg, acc_reg, z_reg, v_reg, x_blk_reg;
    logic [6:0]   bit_reg;
    logic         gbusy_reg;
    logic [127:0] text_reg;
    logic [127:0] m;
    logic [127:0] ctrblk;

    assign m = lead_mask(nbytes);
    assign ctrblk = {nonce, ctr};
    assign rk_addr = rnd_reg;

    always_ff @(posedge aclk) begin
        rk_rd_reg <= rk_mem[rk_addr];
        if (busy_reg && kphase_reg) begin
            rk_mem[rnd_reg] <= expk_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; gbusy_reg <= 1'b0; kphase_reg <= 1'b0; rdwait_reg <= 1'b0;
            op_reg <= OP_NONE; rnd_reg <= '0; bit_reg <= '0;
            h_reg <= '0; mask_reg <= '0; acc_reg <= '0;
        end else if (cmd.start) begin
            op_reg <= cmd.op;
            rnd_reg <= '0;
            case (cmd.op)
                OP_KEY_INIT: begin
                    busy_reg <= 1'b1; kphase_reg <= 1'b1; expk_reg <= key;
                    acc_reg <= '0;
                end
                OP_AES_ZERO, OP_AES_J0, OP_AES_CTR: begin
                    busy_reg <= 1'b1; rdwait_reg <= 1'b1;
                    state_reg <= (cmd.op == OP_AES_ZERO) ? 128'd0 :
                                 (cmd.op == OP_AES_J0) ? {nonce, 32'd1} : ctrblk;
                end
                OP_GHASH_AAD: begin
                    gbusy_reg <= 1'b1; bit_reg <= '0; z_reg <= '0;
                    v_reg <= acc_reg ^ (blk & m);
                end
                OP_GHASH_TEXT: begin
                    gbusy_reg <= 1'b1; bit_reg <= '0; z_reg <= '0;
                    v_reg <= acc_reg ^ (decrypt ? (blk & m) : text_reg);
                end
                OP_GHASH_LEN: begin
                    gbusy_reg <= 1'b1; bit_reg <= '0; z_reg <= '0;
                    v_reg <= acc_reg ^ {25'd0, aad_len, 3'd0, 25'd0, text_len, 3'd0};
                end
                default: begin
                end
            endcase
        end else begin
            if (busy_reg && kphase_reg) begin
                expk_reg <= key_step(expk_reg, rcon(rnd_reg + 4'd1));
                if (rnd_reg == 4'd10) begin
                    busy_reg <= 1'b0; kphase_reg <= 1'b0;
                end
                rnd_reg <= rnd_reg + 4'd1;
            end else if (busy_reg) begin
                if (rdwait_reg) begin
                    rdwait_reg <= 1'b0;
                    rnd_reg <= rnd_reg + 4'd1;
                end else if (rnd_reg == 4'd1) begin
                    state_reg <= state_reg ^ rk_rd_reg;
                    rdwait_reg <= 1'b1;
                end else begin
                    state_reg <= aes_round(state_reg, rnd_reg == 4'd11) ^ rk_rd_reg;
                    if (rnd_reg == 4'd11) begin
                        busy_reg <= 1'b0;
                        case (op_reg)
                            OP_AES_ZERO: h_reg <= aes_round(state_reg, 1'b1) ^ rk_rd_reg;
                            OP_AES_J0: mask_reg <= aes_round(state_reg, 1'b1) ^ rk_rd_reg;
                            OP_AES_CTR: text_reg <=
                                ((blk & m) ^ aes_round(state_reg, 1'b1) ^ rk_rd_reg) & m;
                            default: begin
                            end
                        endcase
                    end else begin
                        rdwait_reg <= 1'b1;
                    end
                end
            end
            if (gbusy_reg) begin
                for (int k = 0; k < 4; k++) begin
                end
                z_reg <= h_reg[7'd127 - bit_reg] ? (z_reg ^ v_reg) : z_reg;
                v_reg <= {1'b0, v_reg[127:1]} ^ (v_reg[0] ? {8'he1, 120'd0} : 128'd0);
                bit_reg <= bit_reg + 7'd1;
                if (bit_reg == 7'd127) begin
                    gbusy_reg <= 1'b0;
                    acc_reg <= h_reg[0] ? (z_reg ^ v_reg) : z_reg;
                end
            end
        end
    end

    assign sts.busy = busy_reg || gbusy_reg;
    assign text_out = text_reg;
    assign ghash_out = acc_reg;
    assign mask_out = mask_reg;

endmodule
`default_nettype wire

### rtl/agcm_ctrl.sv
// Controller: command decode, sequencing of datapath operations and message bookkeeping.
`default_nettype none
module agcm_ctrl
    import agcm_pkg::*;
#(
    parameter int TAG_BYTES = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_fire,
    input  wire logic [1:0]    command,
    input  wire logic [127:0]  blk,
    input  wire logic [4:0]    nbytes,
    input  wire logic          key_loaded,
    input  wire logic          decrypt,
    input  wire logic [95:0]   nonce_cfg,
    output logic               in_ready,
    output dp_cmd_t            dcmd,
    input  wire dp_sts_t       dsts,
    output logic [95:0]        nonce,
    output logic [35:0]        aad_len,
    output logic [35:0]        text_len,
    output logic [31:0]        ctr,
    output logic [127:0]       blk_hold,
    output logic [4:0]         nb_hold,
    input  wire logic [127:0]  text_out,
    input  wire logic [127:0]  ghash_out,
    input  wire logic [127:0]  mask_out,
    output logic               res_valid,
    input  wire logic          res_ready,
    output logic [127:0]       res_data,
    output logic [4:0]         res_bytes,
    output logic               res_tag,
    output logic               res_match,
    output logic [1:0]         res_status
);

    typedef enum logic [3:0] {
        S_IDLE, S_KEY, S_HZERO, S_J0, S_CTR, S_GH_TEXT, S_GH_AAD, S_GH_LEN,
        S_WAIT, S_OUT
    } state_t;

    localparam logic [127:0] TAG_MASK = lead_mask(5'(TAG_BYTES));

    state_t state_reg;
    logic [1:0]  phase_reg;
    logic        partial_reg;
    logic        issued_reg;
    state_t      after_reg;

    assign in_ready = (state_reg == S_IDLE) && !res_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; phase_reg <= PH_IDLE; partial_reg <= 1'b0;
            res_valid <= 1'b0; issued_reg <= 1'b0; after_reg <= S_IDLE;
            dcmd <= '{op: OP_NONE, start: 1'b0};
            nonce <= '0; aad_len <= '0; text_len <= '0; ctr <= '0;
        end else begin
            if (dcmd.start) begin
                dcmd.start <= 1'b0;
            end
            if (res_valid && res_ready) begin
                res_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        blk_hold <= blk; nb_hold <= nbytes;
                        res_data <= '0; res_bytes <= '0; res_tag <= 1'b0;
                        res_match <= 1'b0;
                        if (command == CMD_START) begin
                            if (!key_loaded) begin
                                res_status <= ST_NOKEY; res_valid <= 1'b1;
                            end else begin
                                res_status <= ST_OK;
                                nonce <= nonce_cfg;
                                dcmd <= '{op: OP_KEY_INIT, start: 1'b1};
                                state_reg <= S_KEY;
                            end
                        end else if (phase_reg == PH_IDLE) begin
                            res_status <= key_loaded ? ST_ORDER : ST_NOKEY;
                            res_valid <= 1'b1;
                        end else if (command == CMD_AAD) begin
                            if (phase_reg != PH_AAD || partial_reg || nbytes == 5'd0
                                || nbytes > 5'd16
                                || ({1'b0, aad_len} + 37'(nbytes)) > {1'b0, AAD_MAX}) begin
                                res_status <= ST_ORDER; res_valid <= 1'b1;
                            end else begin
                                res_status <= ST_OK;
                                aad_len <= aad_len + 36'(nbytes);
                                partial_reg <= nbytes < 5'd16;
                                dcmd <= '{op: OP_GHASH_AAD, start: 1'b1};
                                state_reg <= S_WAIT; after_reg <= S_IDLE;
                            end
                        end else if (command == CMD_TEXT) begin
                            if ((phase_reg == PH_TEXT && partial_reg) || nbytes == 5'd0
                                || nbytes > 5'd16
                                || ({1'b0, text_len} + 37'(nbytes)) > {1'b0, TEXT_MAX}) begin
                                res_status <= ST_ORDER; res_valid <= 1'b1;
                            end else begin
                                res_status <= ST_OK;
                                phase_reg <= PH_TEXT;
                                partial_reg <= nbytes < 5'd16;
                                text_len <= text_len + 36'(nbytes);
                                ctr <= ctr + 32'd1;
                                state_reg <= S_CTR; issued_reg <= 1'b0;
                            end
                        end else begin
                            res_status <= ST_OK;
                            dcmd <= '{op: OP_GHASH_LEN, start: 1'b1};
                            state_reg <= S_GH_LEN;
                        end
                    end
                end
                S_KEY: begin
                    if (!dcmd.start && !dsts.busy) begin
                        dcmd <= '{op: OP_AES_ZERO, start: 1'b1};
                        state_reg <= S_HZERO;
                    end
                end
                S_HZERO: begin
                    if (!dcmd.start && !dsts.busy) begin
                        dcmd <= '{op: OP_AES_J0, start: 1'b1};
                        state_reg <= S_WAIT; after_reg <= S_IDLE;
                        aad_len <= '0; text_len <= '0; ctr <= 32'd1;
                        partial_reg <= 1'b0; phase_reg <= PH_AAD;
                    end
                end
                S_CTR: begin
                    if (!issued_reg) begin
                        issued_reg <= 1'b1;
                        dcmd <= '{op: OP_AES_CTR, start: 1'b1};
                    end else if (!dcmd.start && !dsts.busy) begin
                        dcmd <= '{op: OP_GHASH_TEXT, start: 1'b1};
                        state_reg <= S_GH_TEXT;
                    end
                end
                S_GH_TEXT: begin
                    if (!dcmd.start && !dsts.busy) begin
                        res_data <= text_out; res_bytes <= nb_hold;
                        res_valid <= 1'b1; state_reg <= S_IDLE;
                    end
                end
                S_GH_LEN: begin
                    if (!dcmd.start && !dsts.busy) begin
                        res_data <= (mask_out ^ ghash_out) & TAG_MASK;
                        res_bytes <= 5'(TAG_BYTES); res_tag <= 1'b1;
                        res_match <= decrypt &&
                            ((blk_hold & TAG_MASK) == ((mask_out ^ ghash_out) & TAG_MASK));
                        res_valid <= 1'b1; phase_reg <= PH_IDLE; partial_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                S_WAIT: begin
                    if (!dcmd.start && !dsts.busy) begin
                        state_reg <= after_reg;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> res_valid)
        else $error("Result dropped while stalled.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |-> state_reg == S_IDLE)
        else $error("Item accepted while busy.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        dcmd.start |=> !dcmd.start)
        else $error("Datapath start held for two cycles.");

endmodule
`default_nettype wire

### rtl/aes128_gcm_engine_top.sv
// Top level of the AES-128-GCM engine: stream ports, configuration registers and wiring.
// A start item runs the key schedule in 11 steps, then two AES passes (hash key and tag
// mask) with handshakes between them before the next item is taken.
// A text block's result appears after one AES pass and then a bit-serial GHASH.
// Additional data and finish each run one bit-serial GHASH multiplication.
// One item is in work at a time; a finished result waits in the output register.
// Reset is synchronous and active low; it clears control state, the message and the key flag.
`default_nettype none
module aes128_gcm_engine_top
    import agcm_pkg::*;
#(
    parameter int TAG_BYTES = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,  // in_high, in_low, in_bytes, pad
    input  wire logic [1:0]   s_tuser,  // command
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata,  // out_high, out_low, out_bytes, pad
    output logic [3:0]        m_tuser,  // is_tag, tag_match, status
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    logic [63:0] key_high_reg, key_low_reg, nonce_high_reg;
    logic [31:0] nonce_low_reg;
    logic        decrypt_reg, key_loaded_reg;
    logic        wr;
    logic [2:0]  ridx;
    dp_cmd_t     dcmd;
    dp_sts_t     dsts;
    logic [95:0] nonce;
    logic [35:0] aad_len, text_len;
    logic [31:0] ctr;
    logic [127:0] blk_hold, text_out, ghash_out, mask_out, res_data;
    logic [4:0]  nb_hold, res_bytes;
    logic        res_tag, res_match;
    logic [1:0]  res_status;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign ridx = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0; key_low_reg <= '0; nonce_high_reg <= '0;
            nonce_low_reg <= '0; decrypt_reg <= 1'b0; key_loaded_reg <= 1'b0;
        end else if (wr && paddr[2:0] == 3'd0) begin
            case (ridx)
                REG_KEY_HI: begin key_high_reg <= pwdata; key_loaded_reg <= 1'b1; end
                REG_KEY_LO: begin key_low_reg <= pwdata; key_loaded_reg <= 1'b1; end
                REG_NONCE_HI: nonce_high_reg <= pwdata;
                REG_NONCE_LO: nonce_low_reg <= pwdata[31:0];
                REG_DECRYPT: decrypt_reg <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_KEY_HI: prdata = key_high_reg;
            REG_KEY_LO: prdata = key_low_reg;
            REG_NONCE_HI: prdata = nonce_high_reg;
            REG_NONCE_LO: prdata = {32'd0, nonce_low_reg};
            REG_DECRYPT: prdata = {63'd0, decrypt_reg};
            default: prdata = '0;
        endcase
    end

    agcm_ctrl #(.TAG_BYTES(TAG_BYTES)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_tvalid && s_tready), .command(s_tuser),
        .blk({s_tdata[63:0], s_tdata[127:64]}), .nbytes(s_tdata[132:128]),
        .key_loaded(key_loaded_reg), .decrypt(decrypt_reg),
        .nonce_cfg({nonce_high_reg, nonce_low_reg}),
        .in_ready(s_tready), .dcmd(dcmd), .dsts(dsts),
        .nonce(nonce), .aad_len(aad_len), .text_len(text_len), .ctr(ctr),
        .blk_hold(blk_hold), .nb_hold(nb_hold),
        .text_out(text_out), .ghash_out(ghash_out), .mask_out(mask_out),
        .res_valid(m_tvalid), .res_ready(m_tready), .res_data(res_data),
        .res_bytes(res_bytes), .res_tag(res_tag), .res_match(res_match),
        .res_status(res_status)
    );

    agcm_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(dcmd), .sts(dsts),
        .key({key_high_reg, key_low_reg}), .nonce(nonce),
        .blk(blk_hold), .nbytes(nb_hold), .decrypt(decrypt_reg),
        .aad_len(aad_len), .text_len(text_len), .ctr(ctr),
        .text_out(text_out), .ghash_out(ghash_out), .mask_out(mask_out)
    );

    assign m_tdata = {3'd0, res_bytes, res_data[63:0], res_data[127:64]};
    assign m_tuser = {res_status, res_match, res_tag};

endmodule
`default_nettype wire
